@@ rtl/core/ffh_pkg.sv @@
// ----------------------------------------------------------------------------
// ffh_pkg
// Types, sizes and codes shared by the first-fit heap allocator modules.
// ----------------------------------------------------------------------------
package ffh_pkg;

  localparam int unsigned MAX_SEGMENTS = 64;
  localparam int unsigned ALIGN_BYTES  = 16;
  localparam int unsigned HEADER_BYTES = 32;

  localparam int IDX_W     = $clog2(MAX_SEGMENTS);
  localparam int CNT_W     = $clog2(MAX_SEGMENTS + 1);
  localparam int CFG_IDX_W = 2;
  localparam int BASE_W    = 47;
  localparam int SIZE_W    = 32;
  localparam int ADDR_W    = 48;
  localparam int LEN_W     = 32;

  localparam logic [BASE_W-1:0] HEAP_BASE_RST = '0;
  localparam logic [SIZE_W-1:0] HEAP_SIZE_RST = 32'd65536;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_FAIL    = 2'd1;
  localparam logic [1:0] ST_FREED   = 2'd2;
  localparam logic [1:0] ST_IGNORED = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE = 2'd1;

  typedef struct packed {
    logic              cmd;
    logic [31:0]       req_size;
    logic [ADDR_W-1:0] free_addr;
  } item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       used_bytes;
  } result_t;

  typedef struct packed {
    logic [LEN_W-1:0] offset;
    logic [LEN_W-1:0] length;
    logic             free;
  } seg_t;

  localparam int SEG_W = $bits(seg_t);

  typedef struct packed {
    logic [BASE_W-1:0] heap_base;
    logic [SIZE_W-1:0] region_bytes;
    logic              rebuild;
  } cfg_state_t;

endpackage

@@ rtl/core/ffh_ram.sv @@
// ----------------------------------------------------------------------------
// ffh_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/ffh_ctrl.sv @@
// ----------------------------------------------------------------------------
// ffh_ctrl
// Sequencer over the segment table: first-fit scan, insert shift, address
// match scan and a compacting merge pass.
// ----------------------------------------------------------------------------
module ffh_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  ffh_pkg::item_t              item,
  input  ffh_pkg::cfg_state_t         cfg,
  output logic                        idle,
  output logic                        done,
  output ffh_pkg::result_t            result,
  output logic                        ram_we,
  output logic [ffh_pkg::IDX_W-1:0]   ram_waddr,
  output ffh_pkg::seg_t               ram_wdata,
  output logic [ffh_pkg::IDX_W-1:0]   ram_raddr,
  input  ffh_pkg::seg_t               ram_rdata
);
  import ffh_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ASCAN = 4'd1;
  localparam logic [3:0] S_SHIFT = 4'd2;
  localparam logic [3:0] S_WNEW  = 4'd3;
  localparam logic [3:0] S_WSEG  = 4'd4;
  localparam logic [3:0] S_FSCAN = 4'd5;
  localparam logic [3:0] S_MERGE = 4'd6;
  localparam logic [3:0] S_MTAIL = 4'd7;

  localparam logic [LEN_W-1:0] HDR   = LEN_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] CMAX  = CNT_W'(MAX_SEGMENTS);

  logic [3:0]        state;
  logic [CNT_W-1:0]  count;
  logic [LEN_W-1:0]  used;
  logic [CNT_W-1:0]  ptr;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  hit_idx;
  seg_t              hit_seg;
  seg_t              new_seg;
  logic              split;
  logic [32:0]       aligned;
  logic [ADDR_W-1:0] fa;
  seg_t              cur;
  logic [IDX_W-1:0]  widx;

  logic              issue;
  logic [33:0]       round_sum;
  logic [32:0]       aligned_next;
  logic              fit;
  logic              split_next;
  logic [ADDR_W-1:0] pay_addr;
  seg_t              ef;
  logic              absorb;
  logic              last_rd;
  logic [LEN_W-1:0]  seg_len;
  logic [LEN_W-1:0]  used_alloc;
  logic [LEN_W-1:0]  len0;

  assign round_sum    = {2'b00, item.req_size} + 34'(ALIGN_BYTES - 1);
  assign aligned_next = 33'((round_sum / ALIGN_BYTES) * ALIGN_BYTES);

  assign fit        = ram_rdata.free && ({1'b0, ram_rdata.length} >= aligned);
  assign split_next = ({2'b00, ram_rdata.length} >= ({1'b0, aligned} + 34'(HEADER_BYTES)
                      + 34'(ALIGN_BYTES))) && (count < CMAX);
  assign pay_addr   = ADDR_W'(cfg.heap_base) + ADDR_W'(ram_rdata.offset)
                      + ADDR_W'(HEADER_BYTES);
  assign last_rd    = (CNT_W'(rd_idx) + CNT_W'(1)) == count;

  // the freed entry is seen as free during the merge pass
  always_comb begin
    ef = ram_rdata;
    if (rd_idx == hit_idx) begin
      ef.free = 1'b1;
    end
  end
  assign absorb = cur.free && ef.free;

  assign seg_len    = split ? aligned[LEN_W-1:0] : hit_seg.length;
  assign used_alloc = used + seg_len + HDR;
  assign len0       = (cfg.region_bytes >= SIZE_W'(HEADER_BYTES))
                      ? cfg.region_bytes - SIZE_W'(HEADER_BYTES) : '0;
  assign idle       = (state == S_IDLE);

  always_comb begin
    issue     = 1'b0;
    ram_raddr = ptr[IDX_W-1:0];
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = cur;
    case (state)
      S_IDLE: begin
        if (cfg.rebuild) begin
          ram_we    = 1'b1;
          ram_wdata = '{offset: '0, length: len0, free: 1'b1};
        end
      end
      S_ASCAN, S_FSCAN: begin
        issue = ptr < count;
      end
      S_SHIFT: begin
        issue     = ptr > CNT_W'(hit_idx);
        ram_we    = rd_vld;
        ram_waddr = rd_idx + IDX_W'(1);
        ram_wdata = ram_rdata;
      end
      S_WNEW: begin
        ram_we    = 1'b1;
        ram_waddr = hit_idx + IDX_W'(1);
        ram_wdata = new_seg;
      end
      S_WSEG: begin
        ram_we    = 1'b1;
        ram_waddr = hit_idx;
        ram_wdata = '{offset: hit_seg.offset, length: seg_len, free: 1'b0};
      end
      S_MERGE: begin
        issue     = ptr < count;
        ram_we    = rd_vld && (rd_idx != '0) && !absorb;
        ram_waddr = widx;
      end
      S_MTAIL: begin
        ram_we    = 1'b1;
        ram_waddr = widx;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= CNT_W'(1);
      used   <= '0;
      rd_vld <= 1'b0;
      done   <= 1'b0;
      ptr    <= '0;
    end else begin
      done   <= 1'b0;
      rd_vld <= issue;
      rd_idx <= ptr[IDX_W-1:0];
      case (state)
        S_IDLE: begin
          ptr <= '0;
          if (cfg.rebuild) begin
            count <= CNT_W'(1);
            used  <= '0;
          end else if (accept) begin
            aligned <= aligned_next;
            fa      <= item.free_addr;
            result  <= '{status: ST_IGNORED, addr: '0, used_bytes: used};
            if (item.cmd == CMD_ALLOC) begin
              if (item.req_size == '0) begin
                result.status <= ST_FAIL;
                done          <= 1'b1;
              end else begin
                state <= S_ASCAN;
              end
            end else if (item.free_addr == '0) begin
              done <= 1'b1;
            end else begin
              state <= S_FSCAN;
            end
          end
        end
        S_ASCAN: begin
          if (issue) begin
            ptr <= ptr + CNT_W'(1);
          end
          if (rd_vld && fit) begin
            rd_vld         <= 1'b0;
            hit_idx        <= rd_idx;
            hit_seg        <= ram_rdata;
            split          <= split_next;
            new_seg.offset <= ram_rdata.offset + HDR + aligned[LEN_W-1:0];
            new_seg.length <= ram_rdata.length - aligned[LEN_W-1:0] - HDR;
            new_seg.free   <= 1'b1;
            if (!split_next) begin
              state <= S_WSEG;
            end else if (!last_rd) begin
              ptr   <= count - CNT_W'(1);
              state <= S_SHIFT;
            end else begin
              state <= S_WNEW;
            end
          end else if (rd_vld && last_rd) begin
            result.status <= ST_FAIL;
            done          <= 1'b1;
            state         <= S_IDLE;
          end
        end
        S_SHIFT: begin
          if (issue) begin
            ptr <= ptr - CNT_W'(1);
          end
          if (rd_vld && (rd_idx == hit_idx + IDX_W'(1))) begin
            rd_vld <= 1'b0;
            state  <= S_WNEW;
          end
        end
        S_WNEW: begin
          state <= S_WSEG;
        end
        S_WSEG: begin
          count  <= count + CNT_W'(split);
          used   <= used_alloc;
          result <= '{status: ST_ALLOC,
                      addr: ADDR_W'(cfg.heap_base) + ADDR_W'(hit_seg.offset)
                            + ADDR_W'(HEADER_BYTES),
                      used_bytes: used_alloc};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_FSCAN: begin
          if (issue) begin
            ptr <= ptr + CNT_W'(1);
          end
          if (rd_vld && (pay_addr == fa)) begin
            rd_vld <= 1'b0;
            if (ram_rdata.free) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end else begin
              used    <= used - ram_rdata.length - HDR;
              hit_idx <= rd_idx;
              ptr     <= '0;
              widx    <= '0;
              state   <= S_MERGE;
            end
          end else if (rd_vld && last_rd) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_MERGE: begin
          if (issue) begin
            ptr <= ptr + CNT_W'(1);
          end
          if (rd_vld) begin
            if (rd_idx == '0) begin
              cur <= ef;
            end else if (absorb) begin
              cur.length <= cur.length + HDR + ef.length;
            end else begin
              widx <= widx + IDX_W'(1);
              cur  <= ef;
            end
            if (last_rd) begin
              rd_vld <= 1'b0;
              state  <= S_MTAIL;
            end
          end
        end
        S_MTAIL: begin
          count  <= CNT_W'(widx) + CNT_W'(1);
          result <= '{status: ST_FREED, addr: '0, used_bytes: used};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // table always holds between one and the maximum number of segments
  assert property (@(posedge clk) disable iff (rst)
    (count >= CNT_W'(1)) && (count <= CMAX))
    else $error("segment count out of range");

  // merge writes only land on entries already read
  assert property (@(posedge clk) disable iff (rst)
    (state == S_MERGE && ram_we) |-> (ram_waddr < rd_idx))
    else $error("merge write overtakes read pointer");

  // insert shift never touches entries at or below the hit
  assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && ram_we) |-> (ram_waddr > hit_idx))
    else $error("shift write below insertion point");

  // a granted block always lies above the header so is never null
  assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_ALLOC) |-> (result.addr != '0))
    else $error("allocation returned null address");

endmodule

@@ rtl/core/first_fit_heap_allocator.sv @@
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit heap allocator with coalescing over an address-ordered table.
// ----------------------------------------------------------------------------
// One command at a time: busy is high from the cycle after start is taken
// until the table walk ends, and a result is shown for one cycle on done,
// which the receiver must take. An allocate scans for the first fitting
// segment and, when that segment is split, shifts the entries above it to
// open a slot; a free costs the match scan plus one pass over the table for
// merging. The limit is the single read port of the segment table, read one
// entry a cycle. A zero-size allocate or a null free answers on the cycle
// after start and never raises busy.
// After reset or a write of either configuration register the table is
// rebuilt as one free segment, which keeps the block busy for one cycle.
module first_fit_heap_allocator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  ffh_pkg::item_t               item,
  output logic                         done,
  output ffh_pkg::result_t             result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ffh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ffh_pkg::BASE_W-1:0]   cfg_data
);
  import ffh_pkg::*;

  cfg_state_t       cfg;
  logic             idle;
  logic             accept;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  seg_t             ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  seg_t             ram_rdata;

  assign busy      = !idle || cfg.rebuild;
  // a command offered in the same cycle goes first
  assign cfg_ready = idle && !cfg.rebuild && !start;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heap_base    <= HEAP_BASE_RST;
      cfg.region_bytes <= HEAP_SIZE_RST;
      cfg.rebuild      <= 1'b1;
    end else begin
      cfg.rebuild <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HEAP_BASE: begin
            cfg.heap_base <= cfg_data;
            cfg.rebuild   <= 1'b1;
          end
          REG_HEAP_SIZE: begin
            cfg.region_bytes <= cfg_data[SIZE_W-1:0];
            cfg.rebuild      <= 1'b1;
          end
          default: begin
            cfg.rebuild <= 1'b0;
          end
        endcase
      end
    end
  end

  ffh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg       (cfg),
    .idle      (idle),
    .done      (done),
    .result    (result),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  ffh_ram #(
    .WIDTH (SEG_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit heap allocator: a directed table of
// allocate and free commands, a table fill and register extremes, then random
// allocate/free traffic with noise frees, under several idling phases and
// heap settings; every result is compared against an in-bench segment table model.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ffh_pkg::*;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  item_t item;
  logic done;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BASE_W-1:0] cfg_data;

  first_fit_heap_allocator dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // model state
  logic [BASE_W-1:0] m_base;
  logic [SIZE_W-1:0] m_size;
  logic [31:0] seg_off [MAX_SEGMENTS];
  logic [31:0] seg_len [MAX_SEGMENTS];
  logic seg_free [MAX_SEGMENTS];
  int unsigned seg_cnt;
  logic [31:0] in_use;

  result_t pending_results [$];
  logic [ADDR_W-1:0] live_addrs [$];
  int unsigned mismatches;
  bit failed;
  int unsigned idle_pct;

  // directed table
  typedef struct {
    item_t in;
    bit known;
    result_t want;
  } dir_row_t;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] payload_of(int unsigned i);
    return ADDR_W'({1'b0, m_base} + 48'(seg_off[i]) + 48'(HEADER_BYTES));
  endfunction

  function automatic void table_rebuild();
    for (int k = 0; k < MAX_SEGMENTS; k++) begin
      seg_off[k] = '0; seg_len[k] = '0; seg_free[k] = 1'b0;
    end
    seg_len[0] = (m_size >= HEADER_BYTES) ? m_size - HEADER_BYTES : '0;
    seg_free[0] = 1'b1;
    seg_cnt = 1;
    in_use = '0;
    live_addrs.delete();
  endfunction

  function automatic void drop_entry(int unsigned i);
    for (int unsigned k = i; k + 1 < seg_cnt; k++) begin
      seg_off[k] = seg_off[k+1]; seg_len[k] = seg_len[k+1]; seg_free[k] = seg_free[k+1];
    end
    seg_cnt--;
  endfunction

  function automatic result_t allocator_step(item_t it);
    result_t r;
    logic [63:0] need, len, s;
    int unsigned j;
    r.status = (it.cmd == CMD_ALLOC) ? ST_FAIL : ST_IGNORED;
    r.addr = '0;
    if (it.cmd == CMD_ALLOC) begin
      if (it.req_size != 0) begin
        need = ((64'(it.req_size) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
        for (int unsigned i = 0; i < seg_cnt; i++) begin
          len = 64'(seg_len[i]);
          if (seg_free[i] && len >= need) begin
            if (len >= need + HEADER_BYTES + ALIGN_BYTES && seg_cnt < MAX_SEGMENTS) begin
              for (int unsigned k = seg_cnt; k > i + 1; k--) begin
                seg_off[k] = seg_off[k-1]; seg_len[k] = seg_len[k-1];
                seg_free[k] = seg_free[k-1];
              end
              seg_off[i+1] = 32'(64'(seg_off[i]) + HEADER_BYTES + need);
              seg_len[i+1] = 32'(len - need - HEADER_BYTES);
              seg_free[i+1] = 1'b1;
              seg_cnt++;
              seg_len[i] = 32'(need);
            end
            seg_free[i] = 1'b0;
            in_use = in_use + seg_len[i] + HEADER_BYTES;
            r.addr = payload_of(i);
            r.status = ST_ALLOC;
            break;
          end
        end
      end
    end else if (it.free_addr != 0) begin
      for (int unsigned i = 0; i < seg_cnt; i++) begin
        if (payload_of(i) == it.free_addr) begin
          if (!seg_free[i]) begin
            seg_free[i] = 1'b1;
            in_use = in_use - seg_len[i] - HEADER_BYTES;
            // merge runs of free neighbours
            j = 0;
            while (j + 1 < seg_cnt) begin
              if (seg_free[j] && seg_free[j+1]) begin
                s = 64'(seg_len[j]) + HEADER_BYTES + 64'(seg_len[j+1]);
                seg_len[j] = s[31:0];
                drop_entry(j + 1);
              end else begin
                j++;
              end
            end
            r.status = ST_FREED;
          end
          break;
        end
      end
    end
    r.used_bytes = in_use;
    return r;
  endfunction

  task automatic wait_drained();
    int unsigned guard;
    guard = 0;
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [BASE_W-1:0] val);
    // let any trailing table walk finish
    wait_drained();
    repeat (140) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_HEAP_BASE) m_base = val;
    else m_size = val[SIZE_W-1:0];
    table_rebuild();
  endtask

  // start stays high after a transaction until the next one or an idle cycle
  task automatic issue(item_t it, bit known = 1'b0, result_t want = '0);
    result_t r;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    do @(posedge clk); while (busy);
    r = allocator_step(it);
    if (known && r !== want) begin
      failed = 1'b1;
      $display("directed row disagrees with model: table %h model %h", want, r);
    end
    pending_results.push_back(r);
    if (it.cmd == CMD_ALLOC && r.status == ST_ALLOC) live_addrs.push_back(r.addr);
  endtask

  function automatic item_t mk(logic c, logic [31:0] sz, logic [ADDR_W-1:0] fa);
    item_t it;
    it.cmd = c; it.req_size = sz; it.free_addr = fa;
    return it;
  endfunction

  function automatic result_t rs(logic [1:0] st, logic [ADDR_W-1:0] a, logic [31:0] u);
    result_t r;
    r.status = st; r.addr = a; r.used_bytes = u;
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status || result.addr !== want.addr ||
            result.used_bytes !== want.used_bytes) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st %0d addr %h used %0d, got st %0d addr %h used %0d",
                     want.status, want.addr, want.used_bytes,
                     result.status, result.addr, result.used_bytes);
        end
      end
    end
  end

  task automatic random_item();
    item_t it;
    int unsigned pick, n;
    pick = $urandom_range(99);
    if (pick < 50) begin
      n = $urandom_range(99);
      if (n < 70) it = mk(CMD_ALLOC, $urandom_range(600, 1), '0);
      else if (n < 90) it = mk(CMD_ALLOC, $urandom_range(8000, 1), 48'($urandom()));
      else it = mk(CMD_ALLOC, $urandom(), 48'({$urandom(), $urandom()}));
    end else if (pick < 88 && live_addrs.size() != 0) begin
      n = $urandom_range(live_addrs.size() - 1);
      it = mk(CMD_FREE, $urandom(), live_addrs[n]);
      live_addrs.delete(n);
    end else begin
      // noise: stale, null or random addresses
      n = $urandom_range(2);
      it = mk(CMD_FREE, $urandom(),
              n == 0 ? 48'h0 : n == 1 ? ADDR_W'({1'b0, m_base} + 48'(HEADER_BYTES)) :
              48'({$urandom(), $urandom()}));
    end
    issue(it);
  endtask

  initial begin
    dir_row_t dir [$];
    logic [ADDR_W-1:0] a0;
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_HEAP_BASE;
    cfg_data = '0;
    mismatches = 0;
    failed = 1'b0;
    idle_pct = 0;
    m_base = HEAP_BASE_RST;
    m_size = HEAP_SIZE_RST;
    table_rebuild();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    a0 = 48'(HEADER_BYTES);
    dir.push_back('{mk(CMD_ALLOC, 32'd0, '0), 1, rs(ST_FAIL, '0, 32'd0)});
    dir.push_back('{mk(CMD_FREE, '0, 48'h0), 1, rs(ST_IGNORED, '0, 32'd0)});
    dir.push_back('{mk(CMD_ALLOC, 32'd1, '0), 1, rs(ST_ALLOC, a0, 32'd48)});
    dir.push_back('{mk(CMD_ALLOC, 32'hFFFF_FFFF, '0), 1, rs(ST_FAIL, '0, 32'd48)});
    dir.push_back('{mk(CMD_FREE, '0, 48'hFFFF_FFFF_FFFF), 1, rs(ST_IGNORED, '0, 32'd48)});
    dir.push_back('{mk(CMD_FREE, '0, 48'(a0 + 48'd1)), 1, rs(ST_IGNORED, '0, 32'd48)});
    dir.push_back('{mk(CMD_ALLOC, 32'd17, '0), 0, '0});
    dir.push_back('{mk(CMD_ALLOC, 32'd32, '0), 0, '0});
    dir.push_back('{mk(CMD_FREE, '0, a0), 1, rs(ST_FREED, '0, 32'd128)});
    dir.push_back('{mk(CMD_FREE, '0, a0), 1, rs(ST_IGNORED, '0, 32'd128)});
    dir.push_back('{mk(CMD_FREE, '0, 48'(a0 + 48'd48)), 0, '0});
    dir.push_back('{mk(CMD_FREE, '0, 48'(a0 + 48'd112)), 0, '0});
    dir.push_back('{mk(CMD_ALLOC, 32'd65504, '0), 0, '0});
    dir.push_back('{mk(CMD_ALLOC, 32'd1, '0), 1, rs(ST_FAIL, '0, 32'd65536)});
    dir.push_back('{mk(CMD_FREE, '1, a0), 1, rs(ST_FREED, '0, 32'd0)});
    foreach (dir[i]) issue(dir[i].in, dir[i].known, dir[i].want);
    wait_drained();

    // fill the table to force the no-split path
    for (int i = 0; i < 70; i++) issue(mk(CMD_ALLOC, $urandom_range(64, 1), '0));
    wait_drained();

    // extremes of the registers
    write_reg(REG_HEAP_SIZE, 47'd0);
    issue(mk(CMD_ALLOC, 32'd16, '0), 1, rs(ST_FAIL, '0, 32'd0));
    write_reg(REG_HEAP_SIZE, 47'd64);
    issue(mk(CMD_ALLOC, 32'd32, '0), 1, rs(ST_ALLOC, 48'(HEADER_BYTES), 32'd64));
    write_reg(REG_HEAP_BASE, 47'h7FFF_FFFF_FFFF);
    write_reg(REG_HEAP_SIZE, 47'hFFFF_FFFF);
    issue(mk(CMD_ALLOC, 32'hFFFF_FFC0, '0));
    issue(mk(CMD_ALLOC, 32'd100, '0));
    for (int i = 0; i < 20; i++) random_item();
    wait_drained();

    // random phases over a few heap settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 50;
        2: idle_pct = 14;
        default: idle_pct = 50;
      endcase
      write_reg(REG_HEAP_BASE, 47'({$urandom(), $urandom()}));
      write_reg(REG_HEAP_SIZE, ph == 3 ? 47'($urandom()) : 47'($urandom_range(12000, 64)));
      for (int i = 0; i < 190; i++) begin
        random_item();
        if (i == 95) wait_drained();
      end
      wait_drained();
    end
    idle_pct = 0;
    write_reg(REG_HEAP_BASE, 47'd0);

    wait_drained();
    repeat (150) @(posedge clk);
    if (!failed && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/core/ffh_pkg.sv
rtl/core/ffh_ram.sv
rtl/core/ffh_ctrl.sv
rtl/core/first_fit_heap_allocator.sv
tb/tb_top.sv
